/* sv/lifn_pkg.sv */
// lifn_pkg: shared widths, opcodes, register indexes and stage structs
// for the leaky integrate-and-fire neuron block
// no dependencies
package lifn_pkg;

  // weight store: eight banks, one per lane of a spike byte
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned LANES      = 8;
  localparam int unsigned WADDR_W    = 12;
  localparam int unsigned LANE_W     = 3;
  localparam int unsigned ROW_W      = WADDR_W - LANE_W;
  localparam int unsigned ROWS       = 1 << ROW_W;

  localparam int unsigned BIDX_W         = 9;
  localparam int unsigned BYTES_PER_STEP = 512;
  localparam int unsigned TIMESTEPS      = 32;
  localparam int unsigned STEP_CNT_W     = $clog2(TIMESTEPS + 1);
  localparam int unsigned STEP_NUM_W     = 5;

  // gated sum of eight 16-bit weights, step accumulator, membrane
  localparam int unsigned SUM_W   = WEIGHT_W + LANE_W;
  localparam int unsigned ACC_W   = 28;
  localparam int unsigned MEM_W   = 32;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned TOTAL_W = 6;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam int unsigned OPC_W = 2;
  localparam logic [OPC_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPC_W-1:0] OP_SPIKE = 2'd1;
  localparam logic [OPC_W-1:0] OP_START = 2'd2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REST      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd3;

  localparam logic signed [MEM_W-1:0] THRESHOLD_RST = 32'sd1000;
  localparam logic [SHIFT_W-1:0]      LEAK_RST      = 5'd3;
  localparam logic signed [MEM_W-1:0] REST_RST      = 32'sd0;
  localparam logic [TOTAL_W-1:0]      LIMIT_RST     = 6'd8;

  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef weight_t [LANES-1:0] weight_row_t;

  // decoded word after the input register
  typedef struct packed {
    logic             valid;
    logic             start;
    logic             last;
    logic [LANES-1:0] spikes;
  } s1_t;

  // accumulator stage to membrane stage
  typedef struct packed {
    logic                    start;
    logic                    emit;
    logic signed [ACC_W-1:0] cur;
    logic [STEP_NUM_W-1:0]   step_num;
    logic                    run_last;
  } s3_t;

endpackage

/* sv/lifn_weight_mem.sv */
// lifn_weight_mem: weight store as eight banks of 512 x 16, one weight
// written per load, one full row of eight read per spike word (registered)
// depends on lifn_pkg
module lifn_weight_mem import lifn_pkg::*; (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [WADDR_W-1:0]   wr_addr,
  input  weight_t              wr_data,
  input  logic                 rd_en,
  input  logic [ROW_W-1:0]     rd_row,
  output weight_row_t          rd_data
);

  for (genvar g = 0; g < LANES; g++) begin : g_bank
    weight_t mem [ROWS];
    weight_t rd_r;

    always_ff @(posedge clk) begin
      if (wr_en && (wr_addr[LANE_W-1:0] == LANE_W'(g))) begin
        mem[wr_addr[WADDR_W-1:LANE_W]] <= wr_data;
      end
    end

    always_ff @(posedge clk) begin
      if (rd_en) begin
        rd_r <= mem[rd_row];
      end
    end

    assign rd_data[g] = rd_r;
  end

endmodule

/* sv/lifn_accum.sv */
// lifn_accum: gated sum of one row of weights, then the step current
// accumulator and the timestep counter
// depends on lifn_pkg
module lifn_accum import lifn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  s1_t         s1,
  input  weight_row_t weights,
  output s3_t         s3
);

  logic                    s2_valid_r;
  logic                    s2_start_r;
  logic                    s2_last_r;
  logic signed [SUM_W-1:0] s2_sum_r;
  logic signed [SUM_W-1:0] sum_nxt;

  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  acc_sum;
  logic [STEP_CNT_W-1:0]    cnt_r;
  logic [STEP_CNT_W-1:0]    cnt_nxt;
  logic [STEP_CNT_W-1:0]    cnt_inc;
  logic                     run_done;
  s3_t                      s3_r;
  s3_t                      s3_nxt;

  // msb of the spike byte gates lane 0
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      if (s1.spikes[LANES-1-i]) begin
        sum_nxt = sum_nxt + SUM_W'(weights[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_start_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1.valid;
      s2_start_r <= s1.start;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_last_r <= s1.last;
      s2_sum_r  <= sum_nxt;
    end
  end

  always_comb begin
    acc_sum  = acc_r + ACC_W'(s2_sum_r);
    cnt_inc  = cnt_r + 1'b1;
    run_done = (cnt_r >= STEP_CNT_W'(TIMESTEPS));
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    s3_nxt          = '0;
    s3_nxt.cur      = acc_sum;
    s3_nxt.step_num = cnt_r[STEP_NUM_W-1:0];
    s3_nxt.run_last = (cnt_inc == STEP_CNT_W'(TIMESTEPS));
    if (s2_valid_r) begin
      if (s2_start_r) begin
        acc_nxt      = '0;
        cnt_nxt      = '0;
        s3_nxt.start = 1'b1;
      end else if (!run_done) begin
        if (s2_last_r) begin
          acc_nxt     = '0;
          cnt_nxt     = cnt_inc;
          s3_nxt.emit = 1'b1;
        end else begin
          acc_nxt = acc_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      cnt_r        <= '0;
      s3_r.start   <= 1'b0;
      s3_r.emit    <= 1'b0;
    end else if (advance) begin
      acc_r        <= acc_nxt;
      cnt_r        <= cnt_nxt;
      s3_r.start   <= s3_nxt.start;
      s3_r.emit    <= s3_nxt.emit;
    end
    if (advance) begin
      s3_r.cur      <= s3_nxt.cur;
      s3_r.step_num <= s3_nxt.step_num;
      s3_r.run_last <= s3_nxt.run_last;
    end
  end

  assign s3 = s3_r;

endmodule

/* sv/lifn_membrane.sv */
// lifn_membrane: leak, integrate and fire on the membrane, spike total,
// and the result register
// depends on lifn_pkg
module lifn_membrane import lifn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     advance,
  input  s3_t                      s3,
  input  logic signed [MEM_W-1:0]  threshold,
  input  logic [SHIFT_W-1:0]       shift_amt,
  input  logic signed [MEM_W-1:0]  rest_value,
  input  logic [TOTAL_W-1:0]       count_limit,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [STEP_NUM_W-1:0]    out_step_number,
  output logic signed [ACC_W-1:0]  out_synaptic_current,
  output logic signed [MEM_W-1:0]  out_membrane_prior,
  output logic signed [MEM_W-1:0]  out_leak_amount,
  output logic signed [MEM_W-1:0]  out_membrane_new,
  output logic                     out_fired,
  output logic [TOTAL_W-1:0]       out_spikes_so_far,
  output logic                     out_collision_flag,
  output logic                     out_run_last
);

  logic signed [MEM_W-1:0] membrane_r;
  logic signed [MEM_W-1:0] membrane_nxt;
  logic [TOTAL_W-1:0]      total_r;
  logic [TOTAL_W-1:0]      total_nxt;
  logic signed [MEM_W-1:0] leak;
  logic signed [MEM_W-1:0] integ;
  logic                    fire;
  logic                    out_valid_r;

  logic [STEP_NUM_W-1:0]   step_number_r;
  logic signed [ACC_W-1:0] current_r;
  logic signed [MEM_W-1:0] prior_r;
  logic signed [MEM_W-1:0] leak_r;
  logic signed [MEM_W-1:0] mem_new_r;
  logic                    fired_r;
  logic [TOTAL_W-1:0]      total_out_r;
  logic                    collision_r;
  logic                    run_last_r;

  always_comb begin
    leak         = membrane_r >>> shift_amt;
    integ        = membrane_r - leak + MEM_W'(s3.cur);
    fire         = (integ >= threshold);
    membrane_nxt = membrane_r;
    total_nxt    = total_r;
    if (s3.start) begin
      membrane_nxt = rest_value;
      total_nxt    = '0;
    end else if (s3.emit) begin
      membrane_nxt = fire ? rest_value : integ;
      if (fire && (total_r != TOTAL_MAX)) begin
        total_nxt = total_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      membrane_r  <= REST_RST;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      membrane_r  <= membrane_nxt;
      total_r     <= total_nxt;
      // a waiting word stays until taken
      out_valid_r <= s3.emit || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s3.emit) begin
      step_number_r <= s3.step_num;
      current_r     <= s3.cur;
      prior_r       <= membrane_r;
      leak_r        <= leak;
      mem_new_r     <= membrane_nxt;
      fired_r       <= fire;
      total_out_r   <= total_nxt;
      collision_r   <= (total_nxt > count_limit);
      run_last_r    <= s3.run_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_step_number      = step_number_r;
  assign out_synaptic_current = current_r;
  assign out_membrane_prior   = prior_r;
  assign out_leak_amount      = leak_r;
  assign out_membrane_new     = mem_new_r;
  assign out_fired            = fired_r;
  assign out_spikes_so_far    = total_out_r;
  assign out_collision_flag   = collision_r;
  assign out_run_last         = run_last_r;

endmodule

/* sv/lif_neuron_spike_accumulator.sv */
// lif_neuron_spike_accumulator: top level of the leaky integrate-and-fire
// neuron; input decode, configuration registers and pipeline hold control
// depends on lifn_pkg, lifn_weight_mem, lifn_accum, lifn_membrane
//
//   channel  direction  handshake            carries
//   in_      input      in_valid / in_stall  opcode, weight load, spike byte
//   out_     output     out_valid/out_stall  one word per finished timestep
//   cfg_     input      cfg_we               threshold, leak, rest, limit
//
// one word accepted per cycle while in_stall is low; a pipeline of four registers
// (weight row read, gated row sum, step accumulator, membrane and result
// register) carries the last spike byte of a timestep on to its result.
// rst_n is synchronous; it clears control state and sets the registers to
// their defaults, the weight store is not cleared.
// the whole pipeline holds only when a new result meets a stalled waiting one.
module lif_neuron_spike_accumulator import lifn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OPC_W-1:0]         in_opcode,
  input  logic [WADDR_W-1:0]       in_weight_index,
  input  logic signed [WEIGHT_W-1:0] in_weight_value,
  input  logic [BIDX_W-1:0]        in_byte_index,
  input  logic [LANES-1:0]         in_spike_byte,
  input  logic                     in_step_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STEP_NUM_W-1:0]    out_step_number,
  output logic signed [ACC_W-1:0]  out_synaptic_current,
  output logic signed [MEM_W-1:0]  out_membrane_prior,
  output logic signed [MEM_W-1:0]  out_leak_amount,
  output logic signed [MEM_W-1:0]  out_membrane_new,
  output logic                     out_fired,
  output logic [TOTAL_W-1:0]       out_spikes_so_far,
  output logic                     out_collision_flag,
  output logic                     out_run_last,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  localparam logic [BIDX_W:0] BYTE_LIMIT = (BIDX_W+1)'(BYTES_PER_STEP);

  logic signed [MEM_W-1:0] threshold_r;
  logic [SHIFT_W-1:0]      shift_amt_r;
  logic signed [MEM_W-1:0] rest_r;
  logic [TOTAL_W-1:0]      limit_r;

  logic        hold;
  logic        advance;
  logic        accept;
  logic        is_spike;
  logic        in_range;
  s1_t         s1_r;
  s1_t         s1_nxt;
  weight_row_t row_data;
  s3_t         s3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RST;
      shift_amt_r  <= LEAK_RST;
      rest_r       <= REST_RST;
      limit_r      <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold_r  <= cfg_wdata;
        CFG_LEAK:      shift_amt_r  <= cfg_wdata[SHIFT_W-1:0];
        CFG_REST:      rest_r       <= cfg_wdata;
        CFG_LIMIT:     limit_r      <= cfg_wdata[TOTAL_W-1:0];
        default:       ;
      endcase
    end
  end

  assign hold     = out_valid && out_stall && s3.emit;
  assign advance  = !hold;
  assign in_stall = hold;
  assign accept   = in_valid && !hold;
  assign is_spike = (in_opcode == OP_SPIKE);
  assign in_range = ({1'b0, in_byte_index} < BYTE_LIMIT);

  // loads and unknown opcodes end here; start and spike words go on
  always_comb begin
    s1_nxt        = '0;
    s1_nxt.valid  = in_valid && (is_spike || (in_opcode == OP_START));
    s1_nxt.start  = (in_opcode == OP_START);
    s1_nxt.last   = is_spike && in_step_last;
    s1_nxt.spikes = (is_spike && in_range) ? in_spike_byte : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (advance) begin
      s1_r.valid <= s1_nxt.valid;
    end
    if (advance) begin
      s1_r.start  <= s1_nxt.start;
      s1_r.last   <= s1_nxt.last;
      s1_r.spikes <= s1_nxt.spikes;
    end
  end

  lifn_weight_mem u_mem (
    .clk     (clk),
    .wr_en   (accept && (in_opcode == OP_LOAD)),
    .wr_addr (in_weight_index),
    .wr_data (in_weight_value),
    .rd_en   (accept && is_spike),
    .rd_row  (in_byte_index[ROW_W-1:0]),
    .rd_data (row_data)
  );

  lifn_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .s1      (s1_r),
    .weights (row_data),
    .s3      (s3)
  );

  lifn_membrane u_membrane (
    .clk                  (clk),
    .rst_n                (rst_n),
    .advance              (advance),
    .s3                   (s3),
    .threshold            (threshold_r),
    .shift_amt            (shift_amt_r),
    .rest_value           (rest_r),
    .count_limit          (limit_r),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_step_number      (out_step_number),
    .out_synaptic_current (out_synaptic_current),
    .out_membrane_prior   (out_membrane_prior),
    .out_leak_amount      (out_leak_amount),
    .out_membrane_new     (out_membrane_new),
    .out_fired            (out_fired),
    .out_spikes_so_far    (out_spikes_so_far),
    .out_collision_flag   (out_collision_flag),
    .out_run_last         (out_run_last)
  );

  // a firing step leaves the membrane at rest
  a_fire_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fired) |-> (out_membrane_new == rest_r))
    else $error("fired step did not return membrane to rest");

  // a quiet step keeps prior minus leak plus current
  a_integrate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fired) |->
      (out_membrane_new == (out_membrane_prior - out_leak_amount
                            + MEM_W'(out_synaptic_current))))
    else $error("membrane update mismatch");

  // collision follows the spike total against the limit
  a_collision: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_collision_flag == (out_spikes_so_far > limit_r)))
    else $error("collision flag inconsistent with spike total");

  // a result never overwrites one that is still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && s3.emit) |=> (out_valid && $stable(out_step_number)))
    else $error("waiting result overwritten");

endmodule
